// File: sv/stack_queue_opcode_engine_macros.svh
// ----------------------------------------------------------------------------
// stack queue opcode engine assertion macros
// shared assertion shorthands clocked on clk; SQOE_ASSERT is disabled while arst_n is low
// ----------------------------------------------------------------------------
`ifndef STACK_QUEUE_OPCODE_ENGINE_MACROS_SVH
`define STACK_QUEUE_OPCODE_ENGINE_MACROS_SVH

// checked outside reset
`define SQOE_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// checked at every edge, reset included
`define SQOE_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: sv/sqoe_pkg.sv
// ----------------------------------------------------------------------------
// sqoe_pkg
// types, constants and helpers shared by the stack queue opcode engine
// ----------------------------------------------------------------------------
package sqoe_pkg;

	localparam int DEPTH    = 32;
	localparam int SLOT_W   = $clog2(DEPTH);
	localparam int CNT_W    = $clog2(DEPTH + 1);
	localparam int VALUE_W  = 32;
	localparam int LINE_W   = 16;
	localparam int STATUS_W = 3;
	localparam int QDEPTH   = 2;
	localparam int Q_PTR_W  = $clog2(QDEPTH);
	localparam int Q_CNT_W  = $clog2(QDEPTH + 1);

	typedef enum logic [1:0] {
		OP_PUSH  = 2'd0,
		OP_PRINT = 2'd1,
		OP_PEEK  = 2'd2,
		OP_SWAP  = 2'd3
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		STAT_VALUE = 3'd0,
		STAT_DONE  = 3'd1,
		STAT_EMPTY = 3'd2,
		STAT_SHORT = 3'd3,
		STAT_FULL  = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_PEEK,
		BK_PRINT,
		BK_SWAP_A,
		BK_SWAP_B,
		BK_SWAP_W
	} bk_state_t;

	typedef struct packed {
		op_t                       op;
		logic signed [VALUE_W-1:0] value;
		logic        [LINE_W-1:0]  line;
	} cmd_t;

	// head of the command queue as seen by the back end
	typedef struct packed {
		logic valid;
		cmd_t cmd;
	} queue_head_t;

	// slot of the entry that sits b places below slot a, circular
	function automatic logic [SLOT_W-1:0] slot_add(input logic [SLOT_W-1:0] a,
	                                               input logic [CNT_W-1:0] b);
		logic [CNT_W:0] s;
		s = (CNT_W+1)'(a) + (CNT_W+1)'(b);
		if (s >= (CNT_W+1)'(DEPTH)) begin
			s = s - (CNT_W+1)'(DEPTH);
		end
		return s[SLOT_W-1:0];
	endfunction

	// slot just above slot a, circular
	function automatic logic [SLOT_W-1:0] slot_dec(input logic [SLOT_W-1:0] a);
		logic [SLOT_W-1:0] r;
		if (a == '0) begin
			r = SLOT_W'(DEPTH - 1);
		end else begin
			r = a - 1'b1;
		end
		return r;
	endfunction

endpackage

// File: sv/sqoe_ram.sv
// ----------------------------------------------------------------------------
// sqoe_ram
// generic single write, single read memory with registered read data
// ----------------------------------------------------------------------------
module sqoe_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// read data holds until the next read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// File: sv/sqoe_front.sv
// ----------------------------------------------------------------------------
// sqoe_front
// accepts opcode requests, decodes them and holds them in a short queue
// ----------------------------------------------------------------------------
`include "stack_queue_opcode_engine_macros.svh"

module sqoe_front (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 op_valid,
	output logic                                 op_ready,
	input  logic [1:0]                           operation,
	input  logic signed [sqoe_pkg::VALUE_W-1:0]  push_value,
	input  logic [sqoe_pkg::LINE_W-1:0]          source_line,
	output sqoe_pkg::queue_head_t                head,
	input  logic                                 pop
);

	sqoe_pkg::cmd_t                      slot_q [sqoe_pkg::QDEPTH];
	logic [sqoe_pkg::Q_PTR_W-1:0]        wr_ptr_q;
	logic [sqoe_pkg::Q_PTR_W-1:0]        rd_ptr_q;
	logic [sqoe_pkg::Q_CNT_W-1:0]        cnt_q;
	logic                                push;
	logic                                take;
	sqoe_pkg::cmd_t                      new_cmd;

	assign op_ready = (cnt_q != sqoe_pkg::Q_CNT_W'(sqoe_pkg::QDEPTH));
	assign push     = op_valid && op_ready;
	assign take     = pop && (cnt_q != '0);

	// decode the opcode field into the command type
	always_comb begin
		new_cmd.op    = sqoe_pkg::op_t'(operation);
		new_cmd.value = push_value;
		new_cmd.line  = source_line;
	end

	assign head.valid = (cnt_q != '0);
	assign head.cmd   = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= new_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				if (wr_ptr_q == sqoe_pkg::Q_PTR_W'(sqoe_pkg::QDEPTH - 1)) begin
					wr_ptr_q <= '0;
				end else begin
					wr_ptr_q <= wr_ptr_q + 1'b1;
				end
			end
			if (take) begin
				if (rd_ptr_q == sqoe_pkg::Q_PTR_W'(sqoe_pkg::QDEPTH - 1)) begin
					rd_ptr_q <= '0;
				end else begin
					rd_ptr_q <= rd_ptr_q + 1'b1;
				end
			end
			if (push && !take) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (take && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	`SQOE_ASSERT(a_queue_no_overflow, (cnt_q <= sqoe_pkg::Q_CNT_W'(sqoe_pkg::QDEPTH)), "command queue overflow")

endmodule

// File: sv/sqoe_back.sv
// ----------------------------------------------------------------------------
// sqoe_back
// carries out queued commands on the entry store and registers the results
// ----------------------------------------------------------------------------
`include "stack_queue_opcode_engine_macros.svh"

module sqoe_back (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 queue_mode,
	input  sqoe_pkg::queue_head_t                head,
	output logic                                 pop,
	output logic                                 res_valid,
	input  logic                                 res_ready,
	output logic signed [sqoe_pkg::VALUE_W-1:0]  read_value,
	output logic [sqoe_pkg::STATUS_W-1:0]        status,
	output logic                                 last_of_run,
	output logic [sqoe_pkg::LINE_W-1:0]          error_line
);

	sqoe_pkg::bk_state_t             state_q, state_d;
	logic [sqoe_pkg::SLOT_W-1:0]     top_q, top_d;
	logic [sqoe_pkg::CNT_W-1:0]      count_q, count_d;
	logic [sqoe_pkg::SLOT_W-1:0]     k_q, k_d;
	logic [sqoe_pkg::LINE_W-1:0]     line_q, line_d;
	logic [sqoe_pkg::VALUE_W-1:0]    tmp_q;
	logic                            tmp_load;

	logic                            ram_we;
	logic [sqoe_pkg::SLOT_W-1:0]     ram_waddr;
	logic [sqoe_pkg::VALUE_W-1:0]    ram_wdata;
	logic                            ram_re;
	logic [sqoe_pkg::SLOT_W-1:0]     ram_raddr;
	logic [sqoe_pkg::VALUE_W-1:0]    ram_rdata;

	logic                            out_free;
	logic                            emit;
	logic [sqoe_pkg::VALUE_W-1:0]    emit_value;
	sqoe_pkg::status_t               emit_status;
	logic                            emit_last;
	logic [sqoe_pkg::LINE_W-1:0]     emit_line;

	logic                            res_valid_q;
	logic signed [sqoe_pkg::VALUE_W-1:0] value_q;
	logic [sqoe_pkg::STATUS_W-1:0]   status_q;
	logic                            last_q;
	logic [sqoe_pkg::LINE_W-1:0]     eline_q;
	logic                            print_last;

	sqoe_ram #(
		.WIDTH(sqoe_pkg::VALUE_W),
		.DEPTH(sqoe_pkg::DEPTH)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign out_free   = !res_valid_q || res_ready;
	assign print_last = (sqoe_pkg::CNT_W'(k_q) + sqoe_pkg::CNT_W'(1)) == count_q;

	always_comb begin
		state_d     = state_q;
		top_d       = top_q;
		count_d     = count_q;
		k_d         = k_q;
		line_d      = line_q;
		tmp_load    = 1'b0;
		pop         = 1'b0;
		ram_we      = 1'b0;
		ram_waddr   = top_q;
		ram_wdata   = ram_rdata;
		ram_re      = 1'b0;
		ram_raddr   = top_q;
		emit        = 1'b0;
		emit_value  = '0;
		emit_status = sqoe_pkg::STAT_DONE;
		emit_last   = 1'b1;
		emit_line   = line_q;
		case (state_q)
			sqoe_pkg::BK_IDLE: begin
				if (head.valid && out_free) begin
					pop       = 1'b1;
					line_d    = head.cmd.line;
					emit_line = head.cmd.line;
					case (head.cmd.op)
						sqoe_pkg::OP_PUSH: begin
							emit = 1'b1;
							if (count_q == sqoe_pkg::CNT_W'(sqoe_pkg::DEPTH)) begin
								emit_status = sqoe_pkg::STAT_FULL;
							end else begin
								ram_we    = 1'b1;
								ram_wdata = head.cmd.value;
								count_d   = count_q + 1'b1;
								if (count_q == '0) begin
									ram_waddr = top_q;
								end else if (queue_mode) begin
									ram_waddr = sqoe_pkg::slot_add(top_q, count_q);
								end else begin
									ram_waddr = sqoe_pkg::slot_dec(top_q);
									top_d     = sqoe_pkg::slot_dec(top_q);
								end
							end
						end
						sqoe_pkg::OP_PRINT: begin
							if (count_q == '0) begin
								emit = 1'b1;
							end else begin
								ram_re  = 1'b1;
								k_d     = '0;
								state_d = sqoe_pkg::BK_PRINT;
							end
						end
						sqoe_pkg::OP_PEEK: begin
							if (count_q == '0) begin
								emit        = 1'b1;
								emit_status = sqoe_pkg::STAT_EMPTY;
							end else begin
								ram_re  = 1'b1;
								state_d = sqoe_pkg::BK_PEEK;
							end
						end
						sqoe_pkg::OP_SWAP: begin
							if (count_q < sqoe_pkg::CNT_W'(2)) begin
								emit        = 1'b1;
								emit_status = sqoe_pkg::STAT_SHORT;
							end else begin
								ram_re  = 1'b1;
								state_d = sqoe_pkg::BK_SWAP_A;
							end
						end
						default: begin
							pop = 1'b0;
						end
					endcase
				end
			end
			sqoe_pkg::BK_PEEK: begin
				if (out_free) begin
					emit        = 1'b1;
					emit_value  = ram_rdata;
					emit_status = sqoe_pkg::STAT_VALUE;
					state_d     = sqoe_pkg::BK_IDLE;
				end
			end
			sqoe_pkg::BK_PRINT: begin
				if (out_free) begin
					emit        = 1'b1;
					emit_value  = ram_rdata;
					emit_status = sqoe_pkg::STAT_VALUE;
					emit_last   = print_last;
					if (print_last) begin
						state_d = sqoe_pkg::BK_IDLE;
					end else begin
						ram_re    = 1'b1;
						ram_raddr = sqoe_pkg::slot_add(top_q,
							sqoe_pkg::CNT_W'(k_q) + sqoe_pkg::CNT_W'(1));
						k_d       = k_q + 1'b1;
					end
				end
			end
			sqoe_pkg::BK_SWAP_A: begin
				// top entry in hand, fetch the one below
				tmp_load  = 1'b1;
				ram_re    = 1'b1;
				ram_raddr = sqoe_pkg::slot_add(top_q, sqoe_pkg::CNT_W'(1));
				state_d   = sqoe_pkg::BK_SWAP_B;
			end
			sqoe_pkg::BK_SWAP_B: begin
				ram_we    = 1'b1;
				ram_waddr = top_q;
				ram_wdata = ram_rdata;
				state_d   = sqoe_pkg::BK_SWAP_W;
			end
			sqoe_pkg::BK_SWAP_W: begin
				if (out_free) begin
					ram_we    = 1'b1;
					ram_waddr = sqoe_pkg::slot_add(top_q, sqoe_pkg::CNT_W'(1));
					ram_wdata = tmp_q;
					emit      = 1'b1;
					state_d   = sqoe_pkg::BK_IDLE;
				end
			end
			default: begin
				state_d = sqoe_pkg::BK_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= sqoe_pkg::BK_IDLE;
			top_q       <= '0;
			count_q     <= '0;
			k_q         <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			top_q   <= top_d;
			count_q <= count_d;
			k_q     <= k_d;
			if (emit) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		line_q <= line_d;
		if (tmp_load) begin
			tmp_q <= ram_rdata;
		end
		if (emit) begin
			value_q  <= emit_value;
			status_q <= emit_status;
			last_q   <= emit_last;
			eline_q  <= emit_line;
		end
	end

	assign res_valid   = res_valid_q;
	assign read_value  = value_q;
	assign status      = status_q;
	assign last_of_run = last_q;
	assign error_line  = eline_q;

	`SQOE_ASSERT(a_count_bounded, (count_q <= sqoe_pkg::CNT_W'(sqoe_pkg::DEPTH)), "entry count above depth")
	`SQOE_ASSERT(a_count_grows_by_one, (count_q != $past(count_q)) |-> (count_q == $past(count_q) + 1'b1), "entry count changed other than by one push")
	`SQOE_ASSERT(a_pop_only_idle, pop |-> (state_q == sqoe_pkg::BK_IDLE), "queue popped while a command is running")
	`SQOE_ASSERT(a_no_write_on_read, (state_q == sqoe_pkg::BK_PRINT || state_q == sqoe_pkg::BK_PEEK) |-> !ram_we, "store written during print or peek")

endmodule

// File: sv/stack_queue_opcode_engine.sv
// ----------------------------------------------------------------------------
// stack_queue_opcode_engine
// bounded stack or queue store driven by push, print all, peek and swap opcodes
// ----------------------------------------------------------------------------
//  channel   direction  handshake                 payload
//  op        in         op_valid / op_ready       operation, push_value, source_line
//  res       out        res_valid / res_ready     read_value, status, last_of_run, error_line
//  cfg       in         cfg_write_en              cfg_write_data (queue_mode)
//
//  a request passes the two entry command queue, then the back end answers a push
//  or any error from idle, a peek after one store read, a swap after two reads and
//  two writes, and a print all with one store read per entry; the store has one read port
//  arst_n clears the store to empty, top slot to zero and stack mode; store
//  words are only read after a push wrote them, so there is no clearing pass
//  a stalled result register holds the back end while the front fills its queue
// ----------------------------------------------------------------------------
module stack_queue_opcode_engine (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// configuration
	input  logic                                 cfg_write_en,
	input  logic                                 cfg_write_data,
	// opcode requests
	input  logic                                 op_valid,
	output logic                                 op_ready,
	input  logic [1:0]                           operation,
	input  logic signed [sqoe_pkg::VALUE_W-1:0]  push_value,
	input  logic [sqoe_pkg::LINE_W-1:0]          source_line,
	// results
	output logic                                 res_valid,
	input  logic                                 res_ready,
	output logic signed [sqoe_pkg::VALUE_W-1:0]  read_value,
	output logic [sqoe_pkg::STATUS_W-1:0]        status,
	output logic                                 last_of_run,
	output logic [sqoe_pkg::LINE_W-1:0]          error_line
);

	// 0 pushes on top, 1 appends below the bottom entry
	logic                  queue_mode_q;
	// queue head and pop strobe between front and back
	sqoe_pkg::queue_head_t head;
	logic                  pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			queue_mode_q <= 1'b0;
		end else if (cfg_write_en) begin
			queue_mode_q <= cfg_write_data;
		end
	end

	// front: accept and decode requests into the command queue
	sqoe_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.op_valid   (op_valid),
		.op_ready   (op_ready),
		.operation  (operation),
		.push_value (push_value),
		.source_line(source_line),
		.head       (head),
		.pop        (pop)
	);

	// back: run commands against the entry store, one result register
	sqoe_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.queue_mode (queue_mode_q),
		.head       (head),
		.pop        (pop),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.read_value (read_value),
		.status     (status),
		.last_of_run(last_of_run),
		.error_line (error_line)
	);

endmodule

// File: test/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// checks the stack queue opcode engine against an in-line predictor: push,
// print all, peek and swap requests in stack and queue mode, empty and full
// corner cases, random sender gaps and receiver stalls
// ----------------------------------------------------------------------------
module testbench;

	// one expected or observed result
	typedef struct packed {
		logic signed [sqoe_pkg::VALUE_W-1:0] value;
		sqoe_pkg::status_t                   stat;
		logic                                last;
		logic        [sqoe_pkg::LINE_W-1:0]  line;
	} result_t;

	// clock, reset and block inputs, all known from time zero
	logic                                  clk            = 1'b0;
	logic                                  arst_n         = 1'b0;
	logic                                  cfg_write_en   = 1'b0;
	logic                                  cfg_write_data = 1'b0;
	logic                                  op_valid       = 1'b0;
	logic                                  op_ready;
	logic [1:0]                            operation      = '0;
	logic signed [sqoe_pkg::VALUE_W-1:0]   push_value     = '0;
	logic [sqoe_pkg::LINE_W-1:0]           source_line    = '0;
	logic                                  res_valid;
	logic                                  res_ready      = 1'b0;
	logic signed [sqoe_pkg::VALUE_W-1:0]   read_value;
	logic [sqoe_pkg::STATUS_W-1:0]         status;
	logic                                  last_of_run;
	logic [sqoe_pkg::LINE_W-1:0]           error_line;

	// predicted store contents and mode
	logic signed [sqoe_pkg::VALUE_W-1:0]   store_words [sqoe_pkg::DEPTH];
	int unsigned                           store_top        = 0;
	int unsigned                           store_count      = 0;
	int unsigned                           deepest_count    = 0;
	logic                                  store_queue_mode = 1'b0;

	// request and result bookkeeping
	sqoe_pkg::cmd_t                        pending_reqs [$];
	result_t                               expected_results [$];
	int unsigned                           reqs_queued      = 0;
	int unsigned                           reqs_taken       = 0;
	int unsigned                           results_seen     = 0;
	int unsigned                           error_statuses   = 0;
	int unsigned                           mismatch_count   = 0;
	int unsigned                           planned_count    = 0;
	int unsigned                           send_idle_pct    = 0;
	int unsigned                           recv_stall_pct   = 0;
	bit                                    req_accepted     = 1'b0;

	stack_queue_opcode_engine dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_write_en   (cfg_write_en),
		.cfg_write_data (cfg_write_data),
		.op_valid       (op_valid),
		.op_ready       (op_ready),
		.operation      (operation),
		.push_value     (push_value),
		.source_line    (source_line),
		.res_valid      (res_valid),
		.res_ready      (res_ready),
		.read_value     (read_value),
		.status         (status),
		.last_of_run    (last_of_run),
		.error_line     (error_line)
	);

	always #4 clk = ~clk;

	// ------------------------------------------------------------------
	// store predictor
	// ------------------------------------------------------------------

	function automatic void queue_result(input logic signed [sqoe_pkg::VALUE_W-1:0] value,
	                                     input sqoe_pkg::status_t stat, input logic last,
	                                     input logic [sqoe_pkg::LINE_W-1:0] line);
		result_t r;
		r.value = value;
		r.stat  = stat;
		r.last  = last;
		r.line  = line;
		expected_results.push_back(r);
	endfunction

	// slot of the entry k places below the top, circular
	function automatic logic [sqoe_pkg::SLOT_W-1:0] slot_of(input int unsigned k);
		return sqoe_pkg::SLOT_W'((store_top + k) % sqoe_pkg::DEPTH);
	endfunction

	// updates the predicted store for one request and queues its results
	task automatic apply_opcode(input sqoe_pkg::cmd_t req);
		logic [sqoe_pkg::SLOT_W-1:0]         slot_a;
		logic [sqoe_pkg::SLOT_W-1:0]         slot_b;
		int unsigned                         k;
		logic signed [sqoe_pkg::VALUE_W-1:0] held;
		case (req.op)
			sqoe_pkg::OP_PUSH: begin
				if (store_count >= sqoe_pkg::DEPTH) begin
					queue_result('0, sqoe_pkg::STAT_FULL, 1'b1, req.line);
				end else begin
					// first entry lands on the top slot in either mode
					if (store_count == 0) begin
						store_words[slot_of(0)] = req.value;
					end else if (store_queue_mode) begin
						store_words[slot_of(store_count)] = req.value;
					end else begin
						store_top = (store_top + sqoe_pkg::DEPTH - 1) % sqoe_pkg::DEPTH;
						store_words[slot_of(0)] = req.value;
					end
					store_count++;
					if (store_count > deepest_count) deepest_count = store_count;
					queue_result('0, sqoe_pkg::STAT_DONE, 1'b1, req.line);
				end
			end
			sqoe_pkg::OP_PRINT: begin
				if (store_count == 0) begin
					queue_result('0, sqoe_pkg::STAT_DONE, 1'b1, req.line);
				end else begin
					// top to bottom, last flag on the bottom entry
					for (k = 0; k < store_count; k++) begin
						queue_result(store_words[slot_of(k)], sqoe_pkg::STAT_VALUE,
						             k + 1 == store_count, req.line);
					end
				end
			end
			sqoe_pkg::OP_PEEK: begin
				if (store_count == 0) begin
					queue_result('0, sqoe_pkg::STAT_EMPTY, 1'b1, req.line);
				end else begin
					queue_result(store_words[slot_of(0)], sqoe_pkg::STAT_VALUE, 1'b1,
					             req.line);
				end
			end
			default: begin
				if (store_count < 2) begin
					queue_result('0, sqoe_pkg::STAT_SHORT, 1'b1, req.line);
				end else begin
					slot_a = slot_of(0);
					slot_b = slot_of(1);
					held = store_words[slot_a];
					store_words[slot_a] = store_words[slot_b];
					store_words[slot_b] = held;
					queue_result('0, sqoe_pkg::STAT_DONE, 1'b1, req.line);
				end
			end
		endcase
	endtask

	// ------------------------------------------------------------------
	// monitor: requests, mode writes and results at the rising edge
	// ------------------------------------------------------------------

	always @(posedge clk) begin
		sqoe_pkg::cmd_t taken;
		result_t        got;
		result_t        want;
		if (arst_n) begin
			// mode writes only happen while the block is idle
			if (cfg_write_en) store_queue_mode = cfg_write_data;

			if (op_valid && op_ready) begin
				taken.op    = sqoe_pkg::op_t'(operation);
				taken.value = push_value;
				taken.line  = source_line;
				apply_opcode(taken);
				reqs_taken++;
				req_accepted = 1'b1;
			end

			if (res_valid && res_ready) begin
				got.value = read_value;
				got.stat  = sqoe_pkg::status_t'(status);
				got.last  = last_of_run;
				got.line  = error_line;
				results_seen++;
				if (got.stat == sqoe_pkg::STAT_EMPTY || got.stat == sqoe_pkg::STAT_SHORT ||
				    got.stat == sqoe_pkg::STAT_FULL)
					error_statuses++;
				if (expected_results.size() == 0) begin
					mismatch_count++;
					$display("%0t: unexpected result, expected none, ", $time,
					         "got value %0d status %0d last %0b line %0d",
					         got.value, got.stat, got.last, got.line);
				end else begin
					want = expected_results.pop_front();
					if (got !== want) begin
						mismatch_count++;
						$display("%0t: result mismatch, expected value %0d status %0d ",
						         $time, want.value, want.stat,
						         "last %0b line %0d, got value %0d status %0d ",
						         want.last, want.line, got.value, got.stat,
						         "last %0b line %0d", got.last, got.line);
					end
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// driver: request channel and result stalls at the falling edge
	// ------------------------------------------------------------------

	always @(negedge clk) begin
		logic           next_valid;
		sqoe_pkg::cmd_t next_req;
		next_valid = op_valid;
		// request taken at the last rising edge
		if (req_accepted) begin
			next_valid   = 1'b0;
			req_accepted = 1'b0;
		end
		if (!next_valid && pending_reqs.size() != 0 &&
		    $urandom_range(99) >= send_idle_pct) begin
			next_req    = pending_reqs.pop_front();
			operation   <= next_req.op;
			push_value  <= next_req.value;
			source_line <= next_req.line;
			next_valid  = 1'b1;
		end
		op_valid  <= next_valid;
		res_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// ------------------------------------------------------------------
	// stimulus
	// ------------------------------------------------------------------

	// queues one request; tracks the fill level the requests will reach
	task automatic send(input sqoe_pkg::op_t op,
	                    input logic signed [sqoe_pkg::VALUE_W-1:0] value,
	                    input logic [sqoe_pkg::LINE_W-1:0] line);
		sqoe_pkg::cmd_t req;
		req.op    = op;
		req.value = value;
		req.line  = line;
		pending_reqs.push_back(req);
		reqs_queued++;
		if (op == sqoe_pkg::OP_PUSH && planned_count < sqoe_pkg::DEPTH) planned_count++;
	endtask

	function automatic logic signed [sqoe_pkg::VALUE_W-1:0] random_value();
		logic signed [sqoe_pkg::VALUE_W-1:0] v;
		case ($urandom_range(15))
			0:       v = 32'sh8000_0000;
			1:       v = 32'sh7fff_ffff;
			2:       v = '0;
			3:       v = '1;
			default: v = $urandom;
		endcase
		return v;
	endfunction

	function automatic logic [sqoe_pkg::LINE_W-1:0] random_line();
		return sqoe_pkg::LINE_W'($urandom_range(65535));
	endfunction

	function automatic sqoe_pkg::op_t pick_op(input int unsigned push_pct);
		sqoe_pkg::op_t op;
		if ($urandom_range(99) < push_pct) begin
			op = sqoe_pkg::OP_PUSH;
		end else begin
			case ($urandom_range(4))
				0:       op = sqoe_pkg::OP_PRINT;
				1, 2:    op = sqoe_pkg::OP_PEEK;
				default: op = sqoe_pkg::OP_SWAP;
			endcase
		end
		return op;
	endfunction

	task automatic send_random(input int unsigned count, input int unsigned push_pct);
		int unsigned i;
		for (i = 0; i < count; i++)
			send(pick_op(push_pct), random_value(), random_line());
	endtask

	// every request taken, every result back, then a settle pause
	// so a swap write-back finishes before the next mode write
	task automatic wait_idle();
		while (reqs_taken != reqs_queued || expected_results.size() != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic write_queue_mode(input logic mode);
		wait_idle();
		cfg_write_en   <= 1'b1;
		cfg_write_data <= mode;
		@(negedge clk);
		cfg_write_en   <= 1'b0;
		@(negedge clk);
	endtask

	initial begin
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// sender gaps light and receiver stalls heavy through the stack mode part
		send_idle_pct  = 21;
		recv_stall_pct = 54;

		// directed, stack mode: empty store cases first
		write_queue_mode(1'b0);
		send(sqoe_pkg::OP_PRINT, random_value(), 16'd0);
		send(sqoe_pkg::OP_PEEK,  random_value(), 16'hffff);
		send(sqoe_pkg::OP_SWAP,  random_value(), 16'd2);
		send(sqoe_pkg::OP_PUSH,  32'sh7fff_ffff, 16'd3);
		// one entry: swap too short, peek and print see it
		send(sqoe_pkg::OP_SWAP,  random_value(), 16'd4);
		send(sqoe_pkg::OP_PEEK,  random_value(), 16'd5);
		send(sqoe_pkg::OP_PRINT, random_value(), 16'd6);
		send(sqoe_pkg::OP_PUSH,  32'sh8000_0000, 16'd7);
		send(sqoe_pkg::OP_PUSH,  '0,             16'd8);
		send(sqoe_pkg::OP_PUSH,  '1,             16'hfffe);
		send(sqoe_pkg::OP_SWAP,  random_value(), 16'd10);
		send(sqoe_pkg::OP_PRINT, random_value(), 16'd11);
		send(sqoe_pkg::OP_PEEK,  random_value(), 16'd12);

		// directed, queue mode: appends go below the bottom entry
		write_queue_mode(1'b1);
		send(sqoe_pkg::OP_PUSH,  32'sh5555_5555, 16'h5555);
		send(sqoe_pkg::OP_PUSH,  32'shaaaa_aaaa, 16'haaaa);
		send(sqoe_pkg::OP_PRINT, random_value(), 16'd15);
		send(sqoe_pkg::OP_SWAP,  random_value(), 16'd16);
		send(sqoe_pkg::OP_PEEK,  random_value(), 16'd17);
		send(sqoe_pkg::OP_PRINT, random_value(), 16'd18);

		// random, stack mode, sender gaps light and receiver stalls heavy
		write_queue_mode(1'b0);
		send_idle_pct  = 21;
		recv_stall_pct = 54;
		send_random(150, 8);

		// random, queue mode, the other way round
		write_queue_mode(1'b1);
		send_idle_pct  = 54;
		recv_stall_pct = 21;
		send_random(150, 8);

		// no idling from here on; stack mode fills the store to the brim
		write_queue_mode(1'b0);
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		send_random(40, 25);
		while (planned_count < sqoe_pkg::DEPTH)
			send(sqoe_pkg::OP_PUSH, random_value(), random_line());
		// pushes on a full store
		send(sqoe_pkg::OP_PUSH, random_value(), random_line());
		send(sqoe_pkg::OP_PUSH, random_value(), random_line());
		send(sqoe_pkg::OP_PRINT, random_value(), random_line());
		send(sqoe_pkg::OP_PUSH, random_value(), random_line());
		send_random(30, 25);

		// sender holds off until the block has drained completely
		wait_idle();
		send_random(30, 25);

		// full store in queue mode
		write_queue_mode(1'b1);
		send_random(40, 25);

		wait_idle();
		$display("covered %0d requests and %0d results, %0d of them error statuses",
		         reqs_taken, results_seen, error_statuses);
		$display("both store modes, store filled to %0d of %0d entries, three stall profiles",
		         deepest_count, sqoe_pkg::DEPTH);
		if (mismatch_count == 0 && expected_results.size() == 0) begin
			$display("testbench passed");
		end else begin
			$display("testbench failed");
		end
		$finish;
	end

	// watchdog, far beyond the slowest legal run
	initial begin
		#4_000_000;
		$display("testbench failed");
		$finish;
	end

endmodule
